// ----- hdl/dofb_pkg.sv -----
// dofb_pkg.sv: shared types, constants and the sine table for the delayed output feedback torque unit
// no dependencies
`default_nettype none

package dofb_pkg;

	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int SINE_IDX_W         = $clog2(SINE_TABLE_ENTRIES);

	localparam longint Q30_ONE     = 64'sd1073741824;
	localparam longint PI_Q30      = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint TWO_PI_Q30  = 64'sd6746518852;

	// one turn in filter units, and the table step split as 2^7 * 45
	localparam logic signed [25:0] FULL_TURN = 26'sd5898240;
	localparam int                 ANGLE_W   = 23;
	localparam logic [22:0]        ANGLE_HALF_STEP = 23'd2880;
	localparam int                 STEP_SHIFT  = 7;
	localparam int                 STEP_Q_W    = ANGLE_W - STEP_SHIFT;
	localparam logic [16:0]        STEP_RECIP  = 17'd93207;
	localparam int                 RECIP_SHIFT = 22;

	localparam logic signed [13:0] ALPHA_NEW = 14'sd3277;
	localparam logic signed [16:0] LIMIT_120 = 17'sd7680;

	typedef enum logic [1:0] {
		REG_GAIN_EXT  = 2'd0,
		REG_GAIN_FLEX = 2'd1,
		REG_DELAY     = 2'd2
	} cfg_reg_t;

	typedef logic signed [15:0] sine_tab_t [SINE_TABLE_ENTRIES];

	typedef struct packed {
		logic signed [15:0] y;
		logic signed [16:0] diff;
	} ring_entry_t;

	typedef struct packed {
		logic        valid;
		ring_entry_t entry;
	} ring_wr_t;

	typedef struct packed {
		logic        valid;
		ring_entry_t entry;
	} ring_rd_t;

	typedef struct packed {
		logic signed [23:0] left;
		logic signed [23:0] right;
	} torque_pair_t;

	typedef struct packed {
		logic         valid;
		torque_pair_t pair;
	} torque_res_t;

	function automatic logic signed [15:0] sine_entry(input int k);
		longint x;
		longint x2;
		longint term;
		longint sum;
		longint r;
		x = (TWO_PI_Q30 * longint'(k)) / SINE_TABLE_ENTRIES;
		if (x > PI_Q30)
			x = x - TWO_PI_Q30;
		if (x > HALF_PI_Q30)
			x = PI_Q30 - x;
		else if (x < -HALF_PI_Q30)
			x = -PI_Q30 - x;
		x2 = (x * x) / Q30_ONE;
		term = x;
		sum = x;
		term = -((term * x2) / Q30_ONE) / 6;
		sum = sum + term;
		term = -((term * x2) / Q30_ONE) / 20;
		sum = sum + term;
		term = -((term * x2) / Q30_ONE) / 42;
		sum = sum + term;
		term = -((term * x2) / Q30_ONE) / 72;
		sum = sum + term;
		term = -((term * x2) / Q30_ONE) / 110;
		sum = sum + term;
		term = -((term * x2) / Q30_ONE) / 156;
		sum = sum + term;
		term = -((term * x2) / Q30_ONE) / 210;
		sum = sum + term;
		r = (sum + 64'sd32768) >>> 16;
		if (r > 64'sd16384)
			r = 64'sd16384;
		else if (r < -64'sd16384)
			r = -64'sd16384;
		return 16'(r);
	endfunction

	function automatic sine_tab_t build_sine_tab();
		sine_tab_t t;
		for (int k = 0; k < SINE_TABLE_ENTRIES; k++)
			t[k] = sine_entry(k);
		return t;
	endfunction

	localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ----- hdl/delayed_output_feedback_torque_unit.sv -----
// channel   | handshake                 | payload
// sample    | sample_valid/sample_ready | left_angle, right_angle (s16, 1/64 deg)
// torque    | torque_valid/torque_ready | left_torque, right_torque (s24, Q12.12)
// cfg       | cfg_valid/cfg_ready       | cfg_index (2b), cfg_data (16b)
//
// one request per clock while sample_ready is high; a result enters the 8-entry output queue from stage 6
// the filter registers feed back into their own update, the ring ram has registered read data
// sample_ready drops when 8 requests are in flight or queued
// a delay write takes cfg_data[6:0], reduced modulo the ring depth as it is taken, with no stall
// reset clears filters, holds, registers and ring fill state; no clearing pass
// depends on dofb_pkg, dofb_sine, dofb_ring, dofb_torque
`default_nettype none

module delayed_output_feedback_torque_unit import dofb_pkg::*; #(
	parameter int RING_DEPTH = 128
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               sample_valid,
	output logic              sample_ready,
	input  wire signed [15:0] left_angle,
	input  wire signed [15:0] right_angle,
	output logic              torque_valid,
	input  wire               torque_ready,
	output logic signed [23:0] left_torque,
	output logic signed [23:0] right_torque,
	input  wire               cfg_valid,
	output logic              cfg_ready,
	input  wire        [1:0]  cfg_index,
	input  wire        [15:0] cfg_data
);

	localparam int FIFO_DEPTH = 8;
	localparam int FW = $clog2(FIFO_DEPTH);

	logic signed [15:0] gain_ext_q, gain_flex_q;
	logic               delay_load;
	logic               accept, pop;
	ring_wr_t           wr;
	ring_rd_t           rd;
	torque_res_t        res;
	torque_pair_t       fifo_q [FIFO_DEPTH];
	logic [FW-1:0]      wptr_q, rptr_q;
	logic [FW:0]        fifo_cnt_q, cred_q;

	assign cfg_ready  = 1'b1;
	assign delay_load = cfg_valid && (cfg_index == REG_DELAY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_ext_q  <= '0;
			gain_flex_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_GAIN_EXT:  gain_ext_q  <= cfg_data;
				REG_GAIN_FLEX: gain_flex_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sample_ready = (cred_q < (FW+1)'(FIFO_DEPTH));
	assign accept       = sample_valid && sample_ready;
	assign torque_valid = fifo_cnt_q != '0;
	assign pop          = torque_valid && torque_ready;

	dofb_sine u_sine (
		.clk        (clk),
		.arst_n     (arst_n),
		.take       (accept),
		.left_angle (left_angle),
		.right_angle(right_angle),
		.wr         (wr)
	);

	dofb_ring #(
		.RING_DEPTH(RING_DEPTH)
	) u_ring (
		.clk        (clk),
		.arst_n     (arst_n),
		.delay_load (delay_load),
		.delay_value(cfg_data[6:0]),
		.wr         (wr),
		.rd         (rd)
	);

	dofb_torque u_torque (
		.clk      (clk),
		.arst_n   (arst_n),
		.gain_ext (gain_ext_q),
		.gain_flex(gain_flex_q),
		.rd       (rd),
		.res      (res)
	);

	// credits cover requests in the pipeline plus queued results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q     <= '0;
			fifo_cnt_q <= '0;
			wptr_q     <= '0;
			rptr_q     <= '0;
		end else begin
			if (accept && !pop)
				cred_q <= cred_q + 1'b1;
			else if (!accept && pop)
				cred_q <= cred_q - 1'b1;
			if (res.valid && !pop)
				fifo_cnt_q <= fifo_cnt_q + 1'b1;
			else if (!res.valid && pop)
				fifo_cnt_q <= fifo_cnt_q - 1'b1;
			if (res.valid)
				wptr_q <= wptr_q + 1'b1;
			if (pop)
				rptr_q <= rptr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid)
			fifo_q[wptr_q] <= res.pair;
	end

	assign left_torque  = fifo_q[rptr_q].left;
	assign right_torque = fifo_q[rptr_q].right;

`ifndef SYNTH
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cred_q <= (FW+1)'(FIFO_DEPTH)) else $error("credit count over queue depth");
	a_queue_within_credit: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_cnt_q <= cred_q) else $error("queued results exceed outstanding requests");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> fifo_cnt_q < cred_q) else $error("result pushed without credit");
`endif

endmodule

`default_nettype wire

// ----- hdl/dofb_ram.sv -----
// dofb_ram.sv: generic ram, one write port and one read port, registered read data
// no dependencies
`default_nettype none

module dofb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire              clk,
	input  wire              we,
	input  wire  [AW-1:0]    waddr,
	input  wire  [WIDTH-1:0] wdata,
	input  wire              re,
	input  wire  [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hdl/dofb_sine.sv -----
// dofb_sine.sv: angle filters, table index, sine lookup and sine difference (stages 1 to 4)
// depends on dofb_pkg
`default_nettype none

module dofb_sine import dofb_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               take,
	input  wire signed [15:0] left_angle,
	input  wire signed [15:0] right_angle,
	output ring_wr_t          wr
);

	function automatic logic signed [15:0] neg_sat(input logic signed [15:0] a);
		return (a == 16'sh8000) ? 16'sh7fff : -a;
	endfunction

	function automatic logic signed [23:0] filter_step(input logic signed [23:0] f,
			input logic signed [15:0] a);
		logic signed [24:0] d;
		logic signed [38:0] p;
		logic signed [38:0] st;
		logic signed [25:0] n;
		d = 25'($signed({a, 8'd0})) - 25'(f);
		p = 39'(d) * 39'(ALPHA_NEW);
		st = (p + 39'sd32768) >>> 16;
		n = 26'(f) + st[25:0];
		if (n > 26'sd8388607)
			return 24'sh7fffff;
		else if (n < -26'sd8388608)
			return 24'sh800000;
		return n[23:0];
	endfunction

	function automatic logic [ANGLE_W-1:0] wrap_angle(input logic signed [23:0] a);
		logic signed [25:0] ax;
		logic signed [25:0] a1;
		logic signed [25:0] a2;
		logic signed [25:0] m;
		ax = 26'(a);
		a1 = ax + FULL_TURN;
		a2 = a1 + FULL_TURN;
		if (ax < 26'sd0)
			m = (a1 < 26'sd0) ? a2 : a1;
		else if (ax >= FULL_TURN)
			m = ax - FULL_TURN;
		else
			m = ax;
		return m[ANGLE_W-1:0];
	endfunction

	function automatic logic [SINE_IDX_W-1:0] table_index(input logic [STEP_Q_W-1:0] q);
		logic [32:0] p;
		logic [32-RECIP_SHIFT:0] k;
		p = 33'(q) * 33'(STEP_RECIP);
		k = p[32:RECIP_SHIFT];
		return (k == (33-RECIP_SHIFT)'(SINE_TABLE_ENTRIES)) ? '0 : k[SINE_IDX_W-1:0];
	endfunction

	logic signed [23:0] lf_q, rf_q;
	logic               v_s1, v_s2, v_s3, v_s4;
	logic [ANGLE_W-1:0] lm, rm;
	logic [ANGLE_W-1:0] lv, rv;
	logic signed [24:0] fdiff;
	logic [STEP_Q_W-1:0]   lq_s2, rq_s2;
	logic signed [16:0]    diff_s2, diff_s3, diff_s4;
	logic [SINE_IDX_W-1:0] lidx_s3, ridx_s3;
	logic signed [15:0]    lsin_s4, rsin_s4;
	logic signed [16:0]    ydiff;

	// filter state doubles as the stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lf_q <= '0;
			rf_q <= '0;
		end else if (take) begin
			lf_q <= filter_step(lf_q, neg_sat(left_angle));
			rf_q <= filter_step(rf_q, right_angle);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= take;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	assign lm    = wrap_angle(lf_q);
	assign rm    = wrap_angle(rf_q);
	assign lv    = lm + ANGLE_HALF_STEP;
	assign rv    = rm + ANGLE_HALF_STEP;
	assign fdiff = 25'(rf_q) - 25'(lf_q);

	always_ff @(posedge clk) begin
		lq_s2   <= lv[ANGLE_W-1:STEP_SHIFT];
		rq_s2   <= rv[ANGLE_W-1:STEP_SHIFT];
		diff_s2 <= fdiff[24:8];
		lidx_s3 <= table_index(lq_s2);
		ridx_s3 <= table_index(rq_s2);
		diff_s3 <= diff_s2;
		lsin_s4 <= SINE_TAB[lidx_s3];
		rsin_s4 <= SINE_TAB[ridx_s3];
		diff_s4 <= diff_s3;
	end

	assign ydiff = 17'(rsin_s4) - 17'(lsin_s4);

	always_comb begin
		wr.valid      = v_s4;
		wr.entry.diff = diff_s4;
		if (ydiff > 17'sd32767)
			wr.entry.y = 16'sh7fff;
		else
			wr.entry.y = ydiff[15:0];
	end

endmodule

`default_nettype wire

// ----- hdl/dofb_ring.sv -----
// dofb_ring.sv: delay ring in one ram, write and delayed read per request, same-entry forwarding
// depends on dofb_pkg and dofb_ram
`default_nettype none

module dofb_ring import dofb_pkg::*; #(
	parameter int RING_DEPTH = 128
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        delay_load,
	input  wire  [6:0] delay_value,
	input  ring_wr_t   wr,
	output ring_rd_t   rd
);

	localparam int AW = $clog2(RING_DEPTH);
	localparam int CW = ((AW > 7) ? AW : 7) + 1;
	localparam int EW = $bits(ring_entry_t);

	// delay modulo ring depth by conditional subtraction of shifted depths
	function automatic logic [6:0] delay_mod(input logic [6:0] v);
		logic [6:0] r;
		r = v;
		for (int i = 6; i >= 0; i--) begin
			if (32'(r) >= 32'(RING_DEPTH << i))
				r = 7'(32'(r) - 32'(RING_DEPTH << i));
		end
		return r;
	endfunction

	logic [6:0]    dmod_q;
	logic [AW-1:0] wp_q;
	logic          filled_q;
	logic [CW-1:0] dmod_x, wp_x, depth_x, rd_x;
	logic [EW-1:0] ram_rdata;
	logic          v_s5, fwd_s5, ok_s5;
	ring_entry_t   fwd_entry_s5;

	assign depth_x = CW'(RING_DEPTH);
	assign dmod_x  = CW'(dmod_q);
	assign wp_x    = CW'(wp_q);
	assign rd_x    = (wp_x >= dmod_x) ? wp_x - dmod_x : wp_x + depth_x - dmod_x;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dmod_q <= '0;
		end else if (delay_load) begin
			dmod_q <= delay_mod(delay_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q     <= '0;
			filled_q <= 1'b0;
		end else if (wr.valid) begin
			if (wp_q == AW'(RING_DEPTH - 1)) begin
				wp_q     <= '0;
				filled_q <= 1'b1;
			end else begin
				wp_q <= wp_q + 1'b1;
			end
		end
	end

	dofb_ram #(
		.WIDTH(EW),
		.DEPTH(RING_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (wr.valid),
		.waddr(wp_q),
		.wdata(wr.entry),
		.re   (wr.valid),
		.raddr(rd_x[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5   <= 1'b0;
			fwd_s5 <= 1'b0;
			ok_s5  <= 1'b0;
		end else begin
			v_s5   <= wr.valid;
			fwd_s5 <= (dmod_q == '0);
			ok_s5  <= filled_q || (wp_x >= dmod_x);
		end
	end

	always_ff @(posedge clk) begin
		fwd_entry_s5 <= wr.entry;
	end

	// entries not yet written since reset read as zero
	always_comb begin
		rd.valid = v_s5;
		if (fwd_s5)
			rd.entry = fwd_entry_s5;
		else if (ok_s5)
			rd.entry = ring_entry_t'(ram_rdata);
		else
			rd.entry = '0;
	end

`ifndef SYNTH
	a_delay_below_depth: assert property (@(posedge clk) disable iff (!arst_n)
		dmod_x < depth_x) else $error("reduced delay not below ring depth");
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wp_x < depth_x) else $error("write position out of range");
	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rd_x < depth_x) else $error("read position out of range");
`endif

endmodule

`default_nettype wire

// ----- hdl/dofb_torque.sv -----
// dofb_torque.sv: gain products, side selection, rounding and torque hold (stage 6)
// depends on dofb_pkg
`default_nettype none

module dofb_torque import dofb_pkg::*; (
	input  wire               clk,
	input  wire               arst_n,
	input  wire signed [15:0] gain_ext,
	input  wire signed [15:0] gain_flex,
	input  ring_rd_t          rd,
	output torque_res_t       res
);

	function automatic logic signed [23:0] rnd(input logic signed [32:0] p);
		logic signed [32:0] s;
		s = p + 33'sd512;
		return {s[32], s[32:10]};
	endfunction

	logic               v_s6;
	logic signed [31:0] pe_s6, pf_s6;
	logic signed [16:0] dd_s6;
	logic signed [23:0] lh_q, rh_q;
	logic signed [23:0] lh_d, rh_d;
	logic               lead_pos, lead_neg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s6 <= 1'b0;
		else
			v_s6 <= rd.valid;
	end

	always_ff @(posedge clk) begin
		pe_s6 <= 32'(gain_ext) * 32'(rd.entry.y);
		pf_s6 <= 32'(gain_flex) * 32'(rd.entry.y);
		dd_s6 <= rd.entry.diff;
	end

	assign lead_pos = !dd_s6[16] && (dd_s6 < LIMIT_120);
	assign lead_neg = dd_s6[16] && (dd_s6 > -LIMIT_120);

	always_comb begin
		lh_d = lh_q;
		rh_d = rh_q;
		if (v_s6) begin
			if (lead_pos) begin
				lh_d = rnd(33'(pe_s6));
				rh_d = rnd(-33'(pf_s6));
			end else if (lead_neg) begin
				rh_d = rnd(-33'(pe_s6));
				lh_d = rnd(33'(pf_s6));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lh_q <= '0;
			rh_q <= '0;
		end else if (v_s6) begin
			lh_q <= lh_d;
			rh_q <= rh_d;
		end
	end

	assign res.valid      = v_s6;
	assign res.pair.left  = lh_d;
	assign res.pair.right = rh_d;

endmodule

`default_nettype wire
